// ----- sv/mfa_pkg.sv -----
// Package for the mixed fraction adder: widths and shared types.
package mfa_pkg;

  localparam int unsigned WholeWidthDef = 32;
  localparam int unsigned FracWidthDef  = 16;
  localparam int unsigned OutWidth      = 32;

  // Operation selected for the shared divider
  typedef enum logic [0:0] {
    DIV_QUOT = 1'b0,
    DIV_REM  = 1'b1
  } div_op_e;

endpackage

// ----- sv/mfa_if.sv -----
// Valid/ready channel interface carrying one mixed fraction transaction.
interface mfa_in_if #(
  parameter int unsigned WW = 32,
  parameter int unsigned FW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [WW-1:0] a_whole;
  logic        [FW-1:0] a_num;
  logic        [FW-1:0] a_den;
  logic signed [WW-1:0] b_whole;
  logic        [FW-1:0] b_num;
  logic        [FW-1:0] b_den;
  modport source (output valid, a_whole, a_num, a_den, b_whole, b_num, b_den, input ready);
  modport sink (input valid, a_whole, a_num, a_den, b_whole, b_num, b_den, output ready);
endinterface

interface mfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sum_whole;
  logic        [31:0] sum_num;
  logic        [31:0] sum_den;
  logic               overflow;
  modport source (output valid, sum_whole, sum_num, sum_den, overflow, input ready);
  modport sink (input valid, sum_whole, sum_num, sum_den, overflow, output ready);
endinterface

// ----- sv/mfa_div.sv -----
// Restoring divider, one quotient bit per cycle; returns quotient and remainder.
module mfa_div import mfa_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quot_q, quot_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[W-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = W'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[W-2:0], 1'b1};
      end else begin
        rem_d  = trial[W-1:0];
        quot_d = {quot_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

// ----- sv/mixed_fraction_adder_core.sv -----
// Mixed fraction adder: adds two mixed fractions and normalises the result.
//
// Usage: one input channel carries both operands (whole part, numerator,
// denominator each); one output channel returns whole part, overflow flag,
// numerator and denominator (reduced if both fractions are present; 0/0 = no fraction).
// Transactions follow valid/ready; an input is taken at a clock edge with
// both high. The block handles one transaction at a time: ready is low from
// acceptance until the result has been taken, and rises the cycle after.
// All division goes through one shared restoring divider of
// 2*FRAC_WIDTH+1 bits, one quotient bit per cycle. A transaction with both
// fractions present needs the Euclid steps of two gcds plus up to five
// further divisions and the multiply and compare steps. With a fraction
// missing the result is valid the cycle after acceptance.
// If the receiver stalls, the result is held and no new input is taken.
// Reset (asynchronous, active low) returns the sequencer to idle and drops
// the output valid; no clearing pass is needed.
module mixed_fraction_adder_core import mfa_pkg::*; #(
  parameter int unsigned WHOLE_WIDTH = WholeWidthDef,
  parameter int unsigned FRAC_WIDTH  = FracWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  mfa_in_if.sink    in_i,
  mfa_out_if.source out_o
);
  // One spare bit holds the sum of two products; capped at 64-bit modular
  localparam int unsigned DV = (2 * FRAC_WIDTH + 1 > 64) ? 64 : 2 * FRAC_WIDTH + 1;
  localparam int unsigned WW = WHOLE_WIDTH;
  localparam int unsigned EW = ((WW > DV) ? WW : DV) + 2;
  localparam logic [EW-1:0] MaxPos = EW'({1'b0, {(WW-1){1'b1}}});

  typedef enum logic [4:0] {
    S_IDLE, S_G1, S_G1W, S_AG, S_AGW, S_BG, S_BGW, S_ML, S_MA, S_MB, S_CMP,
    S_CARRY, S_CARRYW, S_ADDC, S_G2, S_G2W, S_RN, S_RNW, S_RD, S_RDW, S_OUT
  } state_e;

  state_e state_q;
  logic [WW-1:0] s_q;
  logic          ovf_q;
  logic [FRAC_WIDTH-1:0] an_q, ad_q, bn_q, bd_q, ag_q, bg_q;
  logic [DV-1:0] x_q, y_q;    // Euclid pair
  logic [DV-1:0] l_q, n_q, r_q, g_q;
  logic [DV-1:0] carry_q;
  logic          valid_q;
  logic [OutWidth-1:0] onum_q, oden_q;

  logic          dstart;
  logic [DV-1:0] ddiv, ddvs;
  logic          ddone;
  logic [DV-1:0] dquot, drem;

  mfa_div #(.W(DV)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .dividend_i(ddiv), .divisor_i(ddvs),
    .done_o(ddone), .quot_o(dquot), .rem_o(drem)
  );

  logic [WW-1:0] aw, bw, ssum;
  logic          ovf_w;
  assign aw    = WW'(in_i.a_whole);
  assign bw    = WW'(in_i.b_whole);
  assign ssum  = aw + bw;
  assign ovf_w = (aw[WW-1] == bw[WW-1]) && (ssum[WW-1] != aw[WW-1]);

  // A malformed n/0 counts as absent
  logic [FRAC_WIDTH-1:0] anz, bnz;
  logic [FRAC_WIDTH:0]   nsum, dsum;
  assign anz  = (in_i.a_den == '0) ? '0 : in_i.a_num;
  assign bnz  = (in_i.b_den == '0) ? '0 : in_i.b_num;
  assign nsum = {1'b0, anz} + {1'b0, bnz};
  assign dsum = {1'b0, in_i.a_den} + {1'b0, in_i.b_den};

  // Carry is positive: overflow when whole part plus carry passes the top
  logic signed [EW-1:0] cwide;
  logic                 cofl;
  assign cwide = EW'(signed'(s_q)) + EW'(carry_q);
  assign cofl  = (cwide > signed'(MaxPos));

  always_comb begin
    dstart = 1'b0;
    ddiv   = x_q;
    ddvs   = y_q;
    case (state_q)
      S_G1, S_G2: dstart = 1'b1;
      S_AG: begin
        dstart = 1'b1; ddiv = DV'(ad_q); ddvs = g_q;
      end
      S_BG: begin
        dstart = 1'b1; ddiv = DV'(bd_q); ddvs = g_q;
      end
      S_CARRY: begin
        dstart = 1'b1; ddiv = n_q; ddvs = l_q;
      end
      S_RN: begin
        dstart = 1'b1; ddiv = r_q; ddvs = g_q;
      end
      S_RD: begin
        dstart = 1'b1; ddiv = l_q; ddvs = g_q;
      end
      default: dstart = 1'b0;
    endcase
  end

  // Shared multiplier: l = ad/g * bd, then an * bd/g, then bn * ad/g
  logic [FRAC_WIDTH-1:0]   mul_a, mul_b;
  logic [2*FRAC_WIDTH-1:0] prod;
  always_comb begin
    mul_a = an_q;
    mul_b = bg_q;
    case (state_q)
      S_ML: begin
        mul_a = ag_q; mul_b = bd_q;
      end
      S_MB: begin
        mul_a = bn_q; mul_b = ag_q;
      end
      default: begin
        mul_a = an_q; mul_b = bg_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      s_q     <= '0;
      ovf_q   <= 1'b0;
      an_q    <= '0;
      bn_q    <= '0;
      ad_q    <= '0;
      bd_q    <= '0;
      ag_q    <= '0;
      bg_q    <= '0;
      x_q     <= '0;
      y_q     <= '0;
      l_q     <= '0;
      n_q     <= '0;
      r_q     <= '0;
      g_q     <= '0;
      carry_q <= '0;
      onum_q  <= '0;
      oden_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_i.valid) begin
          s_q     <= ssum;
          ovf_q   <= ovf_w;
          an_q    <= anz;
          bn_q    <= bnz;
          ad_q    <= in_i.a_den;
          bd_q    <= in_i.b_den;
          carry_q <= '0;
          x_q     <= DV'(in_i.a_den);
          y_q     <= DV'(in_i.b_den);
          if (in_i.a_den == '0 || in_i.b_den == '0) begin
            onum_q  <= OutWidth'(nsum);
            oden_q  <= OutWidth'(dsum);
            valid_q <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_G1;
          end
        end
        S_G1: state_q <= S_G1W;
        S_G1W: if (ddone) begin
          if (drem == '0) begin
            g_q     <= y_q;
            state_q <= S_AG;
          end else begin
            x_q <= y_q; y_q <= drem; state_q <= S_G1;
          end
        end
        S_AG: state_q <= S_AGW;
        S_AGW: if (ddone) begin
          ag_q    <= FRAC_WIDTH'(dquot);
          state_q <= S_BG;
        end
        S_BG: state_q <= S_BGW;
        S_BGW: if (ddone) begin
          bg_q    <= FRAC_WIDTH'(dquot);
          state_q <= S_ML;
        end
        S_ML: begin
          l_q     <= DV'(prod);
          state_q <= S_MA;
        end
        S_MA: begin
          n_q     <= DV'(prod);
          state_q <= S_MB;
        end
        S_MB: begin
          n_q     <= n_q + DV'(prod);
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (n_q >= l_q) begin
            state_q <= S_CARRY;
          end else if (n_q == '0) begin
            onum_q  <= '0;
            oden_q  <= '0;
            valid_q <= 1'b1;
            state_q <= S_OUT;
          end else begin
            r_q     <= n_q;
            x_q     <= n_q;
            y_q     <= l_q;
            state_q <= S_G2;
          end
        end
        S_CARRY: state_q <= S_CARRYW;
        S_CARRYW: if (ddone) begin
          carry_q <= dquot;
          r_q     <= drem;
          state_q <= S_ADDC;
        end
        S_ADDC: begin
          s_q   <= s_q + WW'(carry_q);
          ovf_q <= ovf_q | cofl;
          if (r_q == '0) begin
            onum_q  <= '0;
            oden_q  <= '0;
            valid_q <= 1'b1;
            state_q <= S_OUT;
          end else begin
            x_q     <= r_q;
            y_q     <= l_q;
            state_q <= S_G2;
          end
        end
        S_G2: state_q <= S_G2W;
        S_G2W: if (ddone) begin
          if (drem == '0) begin
            g_q     <= y_q;
            state_q <= S_RN;
          end else begin
            x_q <= y_q; y_q <= drem; state_q <= S_G2;
          end
        end
        S_RN: state_q <= S_RNW;
        S_RNW: if (ddone) begin
          onum_q  <= OutWidth'(dquot);
          state_q <= S_RD;
        end
        S_RD: state_q <= S_RDW;
        S_RDW: if (ddone) begin
          oden_q  <= OutWidth'(dquot);
          valid_q <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: if (out_o.ready) begin
          valid_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = valid_q;
  assign out_o.sum_whole = OutWidth'(signed'(s_q));
  assign out_o.sum_num   = onum_q;
  assign out_o.sum_den   = oden_q;
  assign out_o.overflow  = ovf_q;
endmodule

// ----- tb/sv/mixed_fraction_adder_core_test.sv -----
// Testbench for the mixed fraction adder: random and directed sums checked against a predictor.
`timescale 1ns / 100ps

module mixed_fraction_adder_core_test;
  import mfa_pkg::*;

  typedef struct packed {
    logic signed [31:0] whole;
    logic        [31:0] num;
    logic        [31:0] den;
    logic               ovf;
  } sum_t;

  logic clk_i;
  logic rst_ni;

  mfa_in_if #(.WW(32), .FW(16)) in_if ();
  mfa_out_if                    out_if ();

  mixed_fraction_adder_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sum_t expected_sums[$];
  int   mismatch_count;
  int   burst_left;
  bit   stall_enable;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic sum_t predict_sum(logic [31:0] aw, logic [15:0] an_i, logic [15:0] ad,
                                       logic [31:0] bw, logic [15:0] bn_i, logic [15:0] bd);
    sum_t        r;
    logic [31:0] s;
    logic [63:0] an, bn, l, n, d, g, rem, carry, room, mag;
    bit          ovf;
    an    = (ad == 0) ? 64'd0 : 64'(an_i);
    bn    = (bd == 0) ? 64'd0 : 64'(bn_i);
    s     = aw + bw;
    ovf   = (aw[31] == bw[31]) && (s[31] != aw[31]);
    carry = 0;
    r.num = 0;
    r.den = 0;
    if (ad == 0 || bd == 0) begin
      r.num = 32'(an + bn);
      r.den = 32'(ad) + 32'(bd);
    end else begin
      l = (64'(ad) / gcd_u64(64'(ad), 64'(bd))) * 64'(bd);
      n = an * (l / 64'(ad)) + bn * (l / 64'(bd));
      d = l;
      if (n == 0) begin
      end else if (n > d) begin
        rem   = n % d;
        carry = n / d;
        if (rem != 0) begin
          g     = gcd_u64(rem, d);
          r.num = 32'(rem / g);
          r.den = 32'(d / g);
        end
      end else if (n == d) begin
        carry = 1;
      end else begin
        g     = gcd_u64(n, d);
        r.num = 32'(n / g);
        r.den = 32'(d / g);
      end
    end
    if (carry != 0) begin
      if (s[31]) begin
        mag  = 64'((~s) + 32'd1);
        if (mag == 0) mag = 64'h8000_0000;
        room = 64'h7FFF_FFFF + mag;
      end else begin
        room = 64'h7FFF_FFFF - 64'(s);
      end
      if (carry > room) ovf = 1'b1;
      s = s + 32'(carry);
    end
    r.whole = s;
    r.ovf   = ovf;
    return r;
  endfunction

  // Burst/gap pacing on the sending side
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
  endtask

  task automatic send_sum(logic [31:0] aw, logic [15:0] an, logic [15:0] ad,
                          logic [31:0] bw, logic [15:0] bn, logic [15:0] bd);
    pace_sender();
    @(negedge clk_i);
    in_if.valid   <= 1'b1;
    in_if.a_whole <= aw;
    in_if.a_num   <= an;
    in_if.a_den   <= ad;
    in_if.b_whole <= bw;
    in_if.b_num   <= bn;
    in_if.b_den   <= bd;
    do @(posedge clk_i); while (!in_if.ready);
    expected_sums.push_back(predict_sum(aw, an, ad, bw, bn, bd));
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_sums.size() != 0) @(negedge clk_i);
  endtask

  // Receiver stall pattern, its own rhythm
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!stall_enable) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(0, 9) < 6);
    end
  end

  // Result checker
  initial begin
    sum_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (expected_sums.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected transaction: %0d %0d/%0d ovf=%0b",
                                             out_if.sum_whole, out_if.sum_num,
                                             out_if.sum_den, out_if.overflow);
        end else begin
          want = expected_sums.pop_front();
          if (want.whole !== out_if.sum_whole || want.num !== out_if.sum_num ||
              want.den !== out_if.sum_den || want.ovf !== out_if.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("exp %0d %0d/%0d ovf=%0b, got %0d %0d/%0d ovf=%0b",
                       want.whole, want.num, want.den, want.ovf, out_if.sum_whole,
                       out_if.sum_num, out_if.sum_den, out_if.overflow);
          end
        end
      end
    end
  end

  function automatic logic [15:0] rand_den();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(1, 16));
      1:       return 16'($urandom_range(1, 255));
      2:       return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [31:0] rand_whole();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1:       return 32'h8000_0000 + $urandom_range(0, 3);
      2:       return 32'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_absent_fractions();
    send_sum(32'd5, 16'd0, 16'd0, 32'd7, 16'd0, 16'd0);
    send_sum(32'd1, 16'd3, 16'd4, 32'd2, 16'd0, 16'd0);
    send_sum(32'd1, 16'd0, 16'd0, -32'sd2, 16'd9, 16'd4);     // improper passes through
    send_sum(32'd0, 16'hFFFF, 16'd0, 32'd0, 16'd1, 16'd3);    // malformed n/0
    send_sum(32'd0, 16'd2, 16'd0, 32'd0, 16'hFFFF, 16'd0);
    send_sum(32'd0, 16'hFFFF, 16'hFFFF, 32'd0, 16'd0, 16'd0);
  endtask

  task automatic test_fraction_sums();
    send_sum(32'd0, 16'd1, 16'd4, 32'd0, 16'd1, 16'd4);
    send_sum(32'd0, 16'd1, 16'd2, 32'd0, 16'd1, 16'd2);       // exactly one
    send_sum(32'd3, 16'd0, 16'd5, 32'd4, 16'd0, 16'd7);       // zero sum
    send_sum(32'd0, 16'd7, 16'd3, 32'd0, 16'd5, 16'd3);       // improper, zero remainder
    send_sum(32'd0, 16'd5, 16'd3, 32'd0, 16'd5, 16'd6);
    send_sum(32'd0, 16'hFFFF, 16'hFFFF, 32'd0, 16'hFFFF, 16'hFFFE);
    send_sum(32'd0, 16'hFFFF, 16'd1, 32'd0, 16'hFFFF, 16'd1);
    send_sum(32'd0, 16'd1, 16'hFFFF, 32'd0, 16'd1, 16'hFFFE);
  endtask

  task automatic test_whole_overflow();
    send_sum(32'h7FFF_FFFF, 16'd0, 16'd0, 32'd1, 16'd0, 16'd0);
    send_sum(32'h8000_0000, 16'd0, 16'd0, 32'hFFFF_FFFF, 16'd0, 16'd0);
    send_sum(32'h7FFF_FFFF, 16'd1, 16'd2, 32'd0, 16'd1, 16'd2); // carry overflows
    send_sum(32'h7FFF_FFFE, 16'd3, 16'd2, 32'd0, 16'd3, 16'd2);
    send_sum(32'h8000_0000, 16'd1, 16'd2, 32'h8000_0000, 16'd1, 16'd2);
    send_sum(32'hFFFF_FFFF, 16'd2, 16'd3, 32'd0, 16'd1, 16'd3);
  endtask

  task automatic test_random_sums(int count);
    logic [15:0] ad, bd, an, bn;
    repeat (count) begin
      ad = rand_den();
      bd = rand_den();
      if ($urandom_range(0, 9) == 0) ad = '0;
      if ($urandom_range(0, 9) == 0) bd = '0;
      an = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, ad));
      bn = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, bd));
      send_sum(rand_whole(), an, ad, rand_whole(), bn, bd);
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin
    mismatch_count = 0;
    burst_left     = 0;
    stall_enable   = 1'b0;
    in_if.valid    = 1'b0;
    in_if.a_whole  = '0;
    in_if.a_num    = '0;
    in_if.a_den    = '0;
    in_if.b_whole  = '0;
    in_if.b_num    = '0;
    in_if.b_den    = '0;
    rst_ni         = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_absent_fractions();
    test_fraction_sums();
    wait_drained();                      // sender holds off until all results are in
    stall_enable = 1'b1;
    test_whole_overflow();
    test_random_sums(200);
    stall_enable = 1'b0;
    test_random_sums(50);
    stall_enable = 1'b1;
    test_random_sums(180);
    wait_drained();
    repeat (50) @(negedge clk_i);
    if (mismatch_count == 0 && expected_sums.size() == 0)
      $display("mixed_fraction_adder_core: match");
    else
      $display("mixed_fraction_adder_core: mismatch");
    $finish;
  end

  initial begin
    #100ms;
    $display("mixed_fraction_adder_core: mismatch");
    $finish;
  end

endmodule
